// File: sv/assert_macros.svh
// Assertion macros for the file that carries concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication check failed");

`endif

// File: sv/gxb_pkg.sv
package gxb_pkg;

    localparam int DEFAULT_FRACTION_DIGITS = 4;

    localparam int MAG_W   = 30;
    localparam int COORD_W = 31;
    localparam int FRAC_W  = 3;
    localparam int POW10_W = 20;
    localparam int PROD_W  = MAG_W + POW10_W;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [MAG_W-1:0] MAG_LIMIT     = MAG_W'(1000000000);
    localparam logic [MAG_W-1:0] MAG_LIMIT_D10 = MAG_W'(100000000);
    localparam longint           BOUND_BASE    = 100000;

    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_VT    = 8'h0B;
    localparam logic [7:0] CHAR_FF    = 8'h0C;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_POINT = 8'h2E;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_X     = 8'h58;
    localparam logic [7:0] CHAR_Y     = 8'h59;
    localparam logic [7:0] LOWER_LO   = 8'd96;
    localparam logic [7:0] LOWER_HI   = 8'd123;
    localparam logic [7:0] CASE_BIT   = 8'h20;

    typedef enum logic [1:0] {
        PH_SIGN,
        PH_INT,
        PH_FRAC,
        PH_DONE
    } t_phase;

    typedef enum logic [1:0] {
        AXIS_NONE,
        AXIS_X,
        AXIS_Y
    } t_axis;

    // One finished X/Y word, or an end-of-stream marker.
    typedef struct packed {
        logic              eos;
        t_axis             axis;
        logic              negative;
        logic [MAG_W-1:0]  mag;
        logic [FRAC_W-1:0] frac;
    } t_event;

    // Initial bound magnitude: BOUND_BASE scaled up by the fraction digits, capped.
    function automatic logic [COORD_W-1:0] bound_init(input int fd);
        longint m;
        m = BOUND_BASE;
        for (int i = 0; i < fd; i++) begin
            m = (m > longint'(MAG_LIMIT_D10)) ? longint'(MAG_LIMIT) : m * 10;
        end
        return COORD_W'(m);
    endfunction

    function automatic logic [POW10_W-1:0] pow10(input logic [FRAC_W-1:0] k);
        logic [POW10_W-1:0] p;
        unique case (k)
            3'd0:    p = POW10_W'(1);
            3'd1:    p = POW10_W'(10);
            3'd2:    p = POW10_W'(100);
            3'd3:    p = POW10_W'(1000);
            3'd4:    p = POW10_W'(10000);
            3'd5:    p = POW10_W'(100000);
            3'd6:    p = POW10_W'(1000000);
            default: p = POW10_W'(1);
        endcase
        return p;
    endfunction

endpackage

// File: sv/gxb_front.sv
module gxb_front #(
    parameter int FRACTION_DIGITS = gxb_pkg::DEFAULT_FRACTION_DIGITS
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  logic [7:0]      i_byte_value,
    input  logic            i_end_of_stream,
    output logic            o_push,
    output gxb_pkg::t_event o_event
);
    import gxb_pkg::*;

    localparam logic [FRAC_W-1:0] FracMax = FRAC_W'(FRACTION_DIGITS);

    logic              r_header_done, n_header_done;
    logic [7:0]        r_prev, n_prev;
    logic              r_started, n_started;
    t_axis             r_axis, n_axis;
    logic [MAG_W-1:0]  r_acc, n_acc;
    logic [FRAC_W-1:0] r_frac, n_frac;
    logic              r_neg, n_neg;
    t_phase            r_phase, n_phase;

    logic [7:0]       w_c;
    logic             w_cr, w_sep, w_digit, w_body, w_word_end;
    logic [3:0]       w_d;
    logic [MAG_W-1:0] w_acc10, w_accd, w_acc_digit;
    t_axis            w_class;

    assign w_cr = (i_byte_value == CHAR_CR);
    assign w_c  = (i_byte_value > LOWER_LO && i_byte_value < LOWER_HI)
                  ? (i_byte_value & ~CASE_BIT) : i_byte_value;
    assign w_sep   = (w_c == CHAR_SPACE) || (w_c == CHAR_LF);
    assign w_digit = (w_c >= CHAR_ZERO) && (w_c <= CHAR_NINE);
    assign w_d     = 4'(w_c - CHAR_ZERO);
    assign w_class = (w_c == CHAR_X) ? AXIS_X : ((w_c == CHAR_Y) ? AXIS_Y : AXIS_NONE);

    // Saturating decimal shift-add of one digit into the magnitude.
    assign w_acc10     = (r_acc > MAG_LIMIT_D10) ? MAG_LIMIT : ((r_acc << 3) + (r_acc << 1));
    assign w_accd      = w_acc10 + MAG_W'(w_d);
    assign w_acc_digit = (w_accd > MAG_LIMIT) ? MAG_LIMIT : w_accd;

    assign w_body     = i_accept && !i_end_of_stream && !w_cr && r_header_done;
    assign w_word_end = w_body && w_sep && r_started;

    always_comb begin
        o_push = i_accept && (i_end_of_stream || (w_word_end && (r_axis != AXIS_NONE)));
        o_event.eos      = i_end_of_stream;
        o_event.axis     = r_axis;
        o_event.negative = r_neg;
        o_event.mag      = r_acc;
        o_event.frac     = r_frac;
    end

    always_comb begin
        n_header_done = r_header_done;
        n_prev        = r_prev;
        n_started     = r_started;
        n_axis        = r_axis;
        n_acc         = r_acc;
        n_frac        = r_frac;
        n_neg         = r_neg;
        n_phase       = r_phase;
        if (i_accept && i_end_of_stream) begin
            n_header_done = 1'b0;
            n_prev        = 8'h00;
            n_started     = 1'b0;
            n_axis        = AXIS_NONE;
            n_acc         = '0;
            n_frac        = '0;
            n_neg         = 1'b0;
            n_phase       = PH_SIGN;
        end else if (i_accept && !w_cr && !r_header_done) begin
            if (r_prev == CHAR_LF && i_byte_value == CHAR_LF) begin
                n_header_done = 1'b1;
            end else begin
                n_prev = i_byte_value;
            end
        end else if (w_body && w_sep) begin
            n_started = 1'b0;
            n_axis    = AXIS_NONE;
            n_acc     = '0;
            n_frac    = '0;
            n_neg     = 1'b0;
            n_phase   = PH_SIGN;
        end else if (w_body && !r_started) begin
            n_started = 1'b1;
            n_axis    = w_class;
            n_acc     = '0;
            n_frac    = '0;
            n_neg     = 1'b0;
            n_phase   = PH_SIGN;
        end else if (w_body) begin
            unique case (r_phase)
                PH_SIGN: begin
                    if (w_c == CHAR_TAB || w_c == CHAR_VT || w_c == CHAR_FF) begin
                        n_phase = PH_SIGN;
                    end else if (w_c == CHAR_PLUS || w_c == CHAR_MINUS) begin
                        n_neg   = (w_c == CHAR_MINUS);
                        n_phase = PH_INT;
                    end else if (w_c == CHAR_POINT) begin
                        n_phase = PH_FRAC;
                    end else if (w_digit) begin
                        n_acc   = MAG_W'(w_d);
                        n_phase = PH_INT;
                    end else begin
                        n_phase = PH_DONE;
                    end
                end
                PH_INT: begin
                    if (w_digit) begin
                        n_acc = w_acc_digit;
                    end else if (w_c == CHAR_POINT) begin
                        n_phase = PH_FRAC;
                    end else begin
                        n_phase = PH_DONE;
                    end
                end
                PH_FRAC: begin
                    if (w_digit) begin
                        if (r_frac < FracMax) begin
                            n_acc  = w_acc_digit;
                            n_frac = r_frac + FRAC_W'(1);
                        end
                    end else begin
                        n_phase = PH_DONE;
                    end
                end
                PH_DONE: begin
                    n_phase = PH_DONE;
                end
                default: begin
                    n_phase = PH_DONE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_done <= 1'b0;
            r_prev        <= 8'h00;
            r_started     <= 1'b0;
            r_axis        <= AXIS_NONE;
            r_acc         <= '0;
            r_frac        <= '0;
            r_neg         <= 1'b0;
            r_phase       <= PH_SIGN;
        end else begin
            r_header_done <= n_header_done;
            r_prev        <= n_prev;
            r_started     <= n_started;
            r_axis        <= n_axis;
            r_acc         <= n_acc;
            r_frac        <= n_frac;
            r_neg         <= n_neg;
            r_phase       <= n_phase;
        end
    end

endmodule

// File: sv/gxb_queue.sv
module gxb_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  gxb_pkg::t_event i_event,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_valid,
    output gxb_pkg::t_event o_head
);
    import gxb_pkg::*;

    localparam int PtrW = $clog2(QUEUE_DEPTH);
    localparam int CntW = $clog2(QUEUE_DEPTH + 1);

    t_event          r_mem [QUEUE_DEPTH];
    logic [PtrW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CntW-1:0] r_count;
    logic            w_push, w_pop;

    assign o_full  = (r_count == CntW'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_event;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + PtrW'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + PtrW'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + CntW'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - CntW'(1);
            end
        end
    end

endmodule

// File: sv/gxb_back.sv
module gxb_back #(
    parameter int FRACTION_DIGITS = gxb_pkg::DEFAULT_FRACTION_DIGITS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_q_valid,
    input  gxb_pkg::t_event                      i_q_head,
    output logic                                 o_pop,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [gxb_pkg::COORD_W-1:0]   o_corner_x,
    output logic signed [gxb_pkg::COORD_W-1:0]   o_corner_y,
    output logic                                 o_last_corner
);
    import gxb_pkg::*;

    localparam logic signed [COORD_W-1:0] BoundInit = bound_init(FRACTION_DIGITS);
    localparam logic [FRAC_W-1:0]         FracMax   = FRAC_W'(FRACTION_DIGITS);
    localparam logic [2:0]                LastCorner = 3'd4;

    // Scaling stage: magnitude times the missing power of ten.
    logic              r_a_valid;
    logic [PROD_W-1:0] r_a_prod;
    t_axis             r_a_axis;
    logic              r_a_neg;

    // Signed value stage.
    logic                      r_b_valid;
    logic signed [COORD_W-1:0] r_b_value;
    t_axis                     r_b_axis;

    logic signed [COORD_W-1:0] r_xmin, r_xmax, r_ymin, r_ymax;
    logic [2:0]                r_corner;

    logic                      r_o_valid;
    logic signed [COORD_W-1:0] r_o_x, r_o_y;
    logic                      r_o_last;

    logic                      w_word_pop, w_out_load, w_emit;
    logic [MAG_W-1:0]          w_a_mag;
    logic signed [COORD_W-1:0] w_a_value, w_cx, w_cy;

    assign w_word_pop = i_q_valid && !i_q_head.eos;
    assign w_out_load = !r_o_valid || i_out_ready;
    assign w_emit     = i_q_valid && i_q_head.eos && !r_a_valid && !r_b_valid && w_out_load;
    assign o_pop      = w_word_pop || (w_emit && (r_corner == LastCorner));

    assign w_a_mag   = (r_a_prod > PROD_W'(MAG_LIMIT)) ? MAG_LIMIT : r_a_prod[MAG_W-1:0];
    assign w_a_value = r_a_neg ? -$signed({1'b0, w_a_mag}) : $signed({1'b0, w_a_mag});

    always_comb begin
        unique case (r_corner)
            3'd0:    begin w_cx = r_xmin; w_cy = r_ymin; end
            3'd1:    begin w_cx = r_xmax; w_cy = r_ymin; end
            3'd2:    begin w_cx = r_xmax; w_cy = r_ymax; end
            3'd3:    begin w_cx = r_xmin; w_cy = r_ymax; end
            default: begin w_cx = r_xmin; w_cy = r_ymin; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_a_prod  <= PROD_W'(i_q_head.mag) * PROD_W'(pow10(FracMax - i_q_head.frac));
        r_a_axis  <= i_q_head.axis;
        r_a_neg   <= i_q_head.negative;
        r_b_value <= w_a_value;
        r_b_axis  <= r_a_axis;
        if (w_emit) begin
            r_o_x    <= w_cx;
            r_o_y    <= w_cy;
            r_o_last <= (r_corner == LastCorner);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_o_valid <= 1'b0;
            r_corner  <= '0;
            r_xmin    <= BoundInit;
            r_ymin    <= BoundInit;
            r_xmax    <= -BoundInit;
            r_ymax    <= -BoundInit;
        end else begin
            r_a_valid <= w_word_pop;
            r_b_valid <= r_a_valid;
            if (w_out_load) begin
                r_o_valid <= w_emit;
            end
            if (w_emit) begin
                r_corner <= (r_corner == LastCorner) ? '0 : r_corner + 3'd1;
            end
            if (w_emit && (r_corner == LastCorner)) begin
                r_xmin <= BoundInit;
                r_ymin <= BoundInit;
                r_xmax <= -BoundInit;
                r_ymax <= -BoundInit;
            end else if (r_b_valid && r_b_axis == AXIS_X) begin
                if (r_b_value < r_xmin) r_xmin <= r_b_value;
                if (r_b_value > r_xmax) r_xmax <= r_b_value;
            end else if (r_b_valid && r_b_axis == AXIS_Y) begin
                if (r_b_value < r_ymin) r_ymin <= r_b_value;
                if (r_b_value > r_ymax) r_ymax <= r_b_value;
            end
        end
    end

    assign o_out_valid   = r_o_valid;
    assign o_corner_x    = r_o_x;
    assign o_corner_y    = r_o_y;
    assign o_last_corner = r_o_last;

endmodule

// File: sv/gcode_xy_bounding_box.sv
// XY bounding box of a toolpath text stream. One byte is taken per request, and a new
// request is accepted every clock cycle as long as the four-entry event queue between the
// byte parser and the bounds unit has room. The parser skips the header up to the first
// blank line, drops carriage returns, splits the body into words and accumulates the
// decimal value of X and Y words as it goes; each finished X or Y word becomes one queue
// entry. The bounds unit scales a word's magnitude in one multiplier stage, forms the
// signed value in a second stage and updates the running minimum and maximum, so one word
// retires per cycle. An end-of-stream request waits at the head of the queue until those
// two stages are empty, then the five corners leave the output register one per cycle
// while the consumer is ready: (xmin,ymin), (xmax,ymin), (xmax,ymax), (xmin,ymax),
// (xmin,ymin), the last one flagged. Both parser and bounds return to their reset
// state. Byte input stalls only while the queue is full. The end-of-stream entry keeps its
// queue slot until the fifth corner has been issued, so the queue can fill while the
// corners drain, above all when corner output is held back by the consumer.
module gcode_xy_bounding_box #(
    parameter int FRACTION_DIGITS = gxb_pkg::DEFAULT_FRACTION_DIGITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [7:0]                         i_byte_value,
    input  logic                               i_end_of_stream,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [gxb_pkg::COORD_W-1:0] o_corner_x,
    output logic signed [gxb_pkg::COORD_W-1:0] o_corner_y,
    output logic                               o_last_corner
);
    import gxb_pkg::*;

`include "assert_macros.svh"

    localparam logic signed [COORD_W-1:0] BoundInit = bound_init(FRACTION_DIGITS);

    logic   w_accept, w_push, w_full, w_q_valid, w_pop;
    t_event w_event, w_head;
    logic   w_x_in_range, w_y_in_range, w_last_taken, w_last_shown;

    // The parser commits each byte in the cycle it is accepted, so ready only
    // needs to guarantee room for the one event that byte may produce.
    assign o_in_ready = !w_full;
    assign w_accept   = i_in_valid && o_in_ready;

    gxb_front #(
        .FRACTION_DIGITS(FRACTION_DIGITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (w_accept),
        .i_byte_value   (i_byte_value),
        .i_end_of_stream(i_end_of_stream),
        .o_push         (w_push),
        .o_event        (w_event)
    );

    gxb_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .i_event(w_event),
        .i_pop  (w_pop),
        .o_full (w_full),
        .o_valid(w_q_valid),
        .o_head (w_head)
    );

    gxb_back #(
        .FRACTION_DIGITS(FRACTION_DIGITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (w_q_valid),
        .i_q_head     (w_head),
        .o_pop        (w_pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_corner_x   (o_corner_x),
        .o_corner_y   (o_corner_y),
        .o_last_corner(o_last_corner)
    );

    assign w_x_in_range = (o_corner_x <= BoundInit) && (o_corner_x >= -BoundInit);
    assign w_y_in_range = (o_corner_y <= BoundInit) && (o_corner_y >= -BoundInit);
    assign w_last_taken = o_out_valid && i_out_ready && o_last_corner;
    assign w_last_shown = o_out_valid && o_last_corner;

    // An event is never offered to a full queue; it would be lost silently.
    `ASSERT_IMPL(a_no_queue_overflow, i_clk, i_rst_n, w_push, !w_full)
    // Saturation keeps every corner inside the initial bounds.
    `ASSERT_IMPL(a_corner_x_range, i_clk, i_rst_n, o_out_valid, w_x_in_range)
    `ASSERT_IMPL(a_corner_y_range, i_clk, i_rst_n, o_out_valid, w_y_in_range)
    // A rectangle always restarts at its first corner after the closing one.
    `ASSERT_NEXT(a_restart_after_last, i_clk, i_rst_n, w_last_taken, !w_last_shown)

endmodule

// File: dv/tb_top.sv
module tb_top;

    import gxb_pkg::*;

    // The block is built with its default number of fraction digits, and the
    // predictor below scales every value with the same count.
    localparam int          FRAC_DIGITS = DEFAULT_FRACTION_DIGITS;
    localparam int unsigned MAG_CAP     = 1000000000;
    localparam int unsigned BOUND_SEED  = 100000;
    localparam int          IDLE_LIMIT  = 2000;
    localparam int          HOLD_CYCLES = 300;
    localparam int          DRAIN_CYCLES = 20;

    // One request on the byte side: a character or an end-of-stream marker.
    typedef struct packed {
        logic [7:0] value;
        logic       eos;
    } t_byte_req;

    // One corner of the rectangle as the block should deliver it.
    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic                      last;
    } t_corner;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_ready;
    logic [7:0]                i_byte_value = 8'h00;
    logic                      i_end_of_stream = 1'b0;
    logic                      o_out_valid;
    logic                      i_out_ready = 1'b0;
    logic signed [COORD_W-1:0] o_corner_x;
    logic signed [COORD_W-1:0] o_corner_y;
    logic                      o_last_corner;

    gcode_xy_bounding_box uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_byte_value   (i_byte_value),
        .i_end_of_stream(i_end_of_stream),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_corner_x     (o_corner_x),
        .o_corner_y     (o_corner_y),
        .o_last_corner  (o_last_corner)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Requests still to be offered, and corners that the block still owes us.
    t_byte_req byte_requests[$];
    t_corner   expected_corners[$];
    int        mismatches = 0;

    // ------------------------------------------------------------------
    // Bounding-box predictor. It mirrors the parser and the bounds unit of
    // the block: header skipping, word splitting, the decimal accumulator
    // and the running minimum and maximum per axis.
    // ------------------------------------------------------------------
    logic        header_seen;
    logic [7:0]  last_char;
    logic        in_word;
    logic [7:0]  word_lead;
    int unsigned magnitude;
    int unsigned frac_seen;
    logic        num_negative;
    t_phase      num_phase;
    int          x_lo, x_hi, y_lo, y_hi;

    // Multiply by ten, pinned at the magnitude cap.
    function automatic int unsigned times10_sat(input int unsigned m);
        return (m > MAG_CAP / 10) ? MAG_CAP : m * 10;
    endfunction

    function automatic int unsigned shifted_in(input int unsigned m, input int unsigned d);
        int unsigned t;
        t = times10_sat(m) + d;
        return (t > MAG_CAP) ? MAG_CAP : t;
    endfunction

    task automatic clear_word();
        in_word      = 1'b0;
        word_lead    = 8'h00;
        magnitude    = 0;
        frac_seen    = 0;
        num_negative = 1'b0;
        num_phase    = PH_SIGN;
    endtask

    // Back to the state after reset, which is also the state after each
    // end of stream. The starting bounds are an inverted, empty rectangle.
    task automatic clear_all();
        int unsigned b;
        b = BOUND_SEED;
        repeat (FRAC_DIGITS) b = times10_sat(b);
        header_seen = 1'b0;
        last_char   = 8'h00;
        clear_word();
        x_lo = int'(b);
        y_lo = int'(b);
        x_hi = -int'(b);
        y_hi = -int'(b);
    endtask

    // A finished word: scale the magnitude up to the full fraction width,
    // apply the sign and widen the bounds of its axis.
    task automatic commit_word();
        int unsigned mag;
        int          val;
        mag = magnitude;
        for (int unsigned i = frac_seen; i < FRAC_DIGITS; i++) mag = times10_sat(mag);
        val = num_negative ? -int'(mag) : int'(mag);
        if (word_lead == CHAR_X) begin
            if (val > x_hi) x_hi = val;
            if (val < x_lo) x_lo = val;
        end else if (word_lead == CHAR_Y) begin
            if (val > y_hi) y_hi = val;
            if (val < y_lo) y_lo = val;
        end
    endtask

    // Everything after the letter of a word goes through the number parser.
    // Once the number has ended, the rest of the word is ignored.
    task automatic parse_number_char(input logic [7:0] c);
        logic        is_digit;
        int unsigned digit_val;
        is_digit  = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
        digit_val = 32'(c) - 32'(CHAR_ZERO);
        case (num_phase)
            PH_SIGN: begin
                // Tab, vertical tab and form feed before the number are skipped.
                if (!(c == CHAR_TAB || c == CHAR_VT || c == CHAR_FF)) begin
                    if (c == CHAR_PLUS || c == CHAR_MINUS) begin
                        num_negative = (c == CHAR_MINUS);
                        num_phase    = PH_INT;
                    end else if (c == CHAR_POINT) begin
                        num_phase = PH_FRAC;
                    end else if (is_digit) begin
                        magnitude = digit_val;
                        num_phase = PH_INT;
                    end else begin
                        num_phase = PH_DONE;
                    end
                end
            end
            PH_INT: begin
                if (is_digit) begin
                    magnitude = shifted_in(magnitude, digit_val);
                end else if (c == CHAR_POINT) begin
                    num_phase = PH_FRAC;
                end else begin
                    num_phase = PH_DONE;
                end
            end
            PH_FRAC: begin
                // Fraction digits past the kept count are dropped, not rounded.
                if (is_digit) begin
                    if (frac_seen < FRAC_DIGITS) begin
                        magnitude = shifted_in(magnitude, digit_val);
                        frac_seen++;
                    end
                end else begin
                    num_phase = PH_DONE;
                end
            end
            default: begin
            end
        endcase
    endtask

    task automatic push_corner(input int x, input int y, input logic last);
        t_corner c;
        c.x    = x[COORD_W-1:0];
        c.y    = y[COORD_W-1:0];
        c.last = last;
        expected_corners.push_back(c);
    endtask

    // Advance the predictor by one accepted request. End of stream queues the
    // closed rectangle and clears everything, including a word still open.
    task automatic predict_request(input logic [7:0] raw, input logic eos);
        logic [7:0] c;
        c = raw;
        if (eos) begin
            push_corner(x_lo, y_lo, 1'b0);
            push_corner(x_hi, y_lo, 1'b0);
            push_corner(x_hi, y_hi, 1'b0);
            push_corner(x_lo, y_hi, 1'b0);
            push_corner(x_lo, y_lo, 1'b1);
            clear_all();
        end else if (c != CHAR_CR) begin
            if (!header_seen) begin
                // The header ends at the first blank line.
                if (last_char == CHAR_LF && c == CHAR_LF) header_seen = 1'b1;
                else last_char = c;
            end else begin
                if (c > LOWER_LO && c < LOWER_HI) c = c & ~CASE_BIT;
                if (c == CHAR_SPACE || c == CHAR_LF) begin
                    if (in_word) begin
                        commit_word();
                        clear_word();
                    end
                end else if (!in_word) begin
                    clear_word();
                    in_word   = 1'b1;
                    word_lead = c;
                end else begin
                    parse_number_char(c);
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus building.
    // ------------------------------------------------------------------
    task automatic push_byte(input logic [7:0] b);
        t_byte_req r;
        r.value = b;
        r.eos   = 1'b0;
        byte_requests.push_back(r);
    endtask

    // The byte lane carries noise on an end-of-stream request; the block
    // must ignore it.
    task automatic push_eos();
        t_byte_req r;
        r.value = 8'($urandom_range(0, 255));
        r.eos   = 1'b1;
        byte_requests.push_back(r);
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) push_byte(s[i]);
    endtask

    task automatic push_digit();
        push_byte(CHAR_ZERO + 8'($urandom_range(0, 9)));
    endtask

    task automatic push_separator();
        case ($urandom_range(0, 3))
            0: push_byte(CHAR_SPACE);
            1: push_byte(CHAR_LF);
            2: begin
                push_byte(CHAR_CR);
                push_byte(CHAR_LF);
            end
            default: begin
                push_byte(CHAR_SPACE);
                push_byte(CHAR_SPACE);
            end
        endcase
    endtask

    // A well-formed coordinate word with random content: either case of the
    // letter, optional blank padding, sign, integer and fraction digits, and
    // now and then a stray character that ends the number early. A few words
    // carry enough digits to run into saturation.
    task automatic push_coord_word();
        int r;
        int n;
        case ($urandom_range(0, 3))
            0: push_byte(CHAR_X);
            1: push_byte(CHAR_X | CASE_BIT);
            2: push_byte(CHAR_Y);
            default: push_byte(CHAR_Y | CASE_BIT);
        endcase
        if ($urandom_range(0, 9) == 0) begin
            case ($urandom_range(0, 2))
                0: push_byte(CHAR_TAB);
                1: push_byte(CHAR_VT);
                default: push_byte(CHAR_FF);
            endcase
        end
        r = $urandom_range(0, 99);
        if (r < 40) push_byte(CHAR_MINUS);
        else if (r < 55) push_byte(CHAR_PLUS);
        r = $urandom_range(0, 99);
        n = (r < 10) ? 0 : (r < 20) ? $urandom_range(9, 11) : $urandom_range(1, 6);
        repeat (n) push_digit();
        if ($urandom_range(0, 1) == 1) begin
            push_byte(CHAR_POINT);
            repeat ($urandom_range(0, 7)) push_digit();
        end
        if ($urandom_range(0, 9) == 0) push_byte(8'($urandom_range(0, 255)));
    endtask

    // A word with another lead: G, a random capital letter, a zero byte or any byte at all,
    // followed by a few digits. A random lead can still be X or Y, so the bounds may see it.
    task automatic push_other_word();
        case ($urandom_range(0, 3))
            0: push_text("G");
            1: push_byte(8'($urandom_range(65, 90)));
            2: push_byte(8'h00);
            default: push_byte(8'($urandom_range(0, 255)));
        endcase
        repeat ($urandom_range(0, 4)) push_digit();
    endtask

    // One file: a short header, the blank line, a few words, end of stream.
    // Some files never close their header, and some end in the middle of a
    // word.
    task automatic push_stream();
        int lines;
        int words;
        int kind;
        logic [7:0] c;
        lines = $urandom_range(0, 1);
        repeat (lines) begin
            repeat ($urandom_range(1, 4)) begin
                do c = 8'($urandom_range(0, 255)); while (c == CHAR_LF);
                push_byte(c);
            end
            push_byte(CHAR_LF);
        end
        if (lines == 0) push_byte(CHAR_LF);
        if ($urandom_range(0, 99) >= 8) begin
            if ($urandom_range(0, 3) == 0) push_byte(CHAR_CR);
            push_byte(CHAR_LF);
        end
        words = $urandom_range(1, 5);
        for (int w = 0; w < words; w++) begin
            kind = $urandom_range(0, 99);
            if (kind < 70) begin
                push_coord_word();
            end else if (kind < 85) begin
                push_other_word();
            end else begin
                repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(0, 255)));
            end
            if (w != words - 1 || $urandom_range(0, 99) >= 15) push_separator();
        end
        push_eos();
    endtask

    // ------------------------------------------------------------------
    // Gap lengths for both sides: mostly none or short, a few long, and now
    // and then a calm stretch with no gaps at all.
    // ------------------------------------------------------------------
    function automatic int pick_gap(inout int calm);
        int r;
        if (calm != 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // ------------------------------------------------------------------
    // Byte-side driver. A new request is loaded only when the previous one
    // has gone through, so valid and the payload hold steady while the block
    // stalls.
    // ------------------------------------------------------------------
    t_byte_req next_req;
    int        send_gap = 0;
    int        send_calm = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || o_in_ready) begin
            if (send_gap != 0) begin
                send_gap--;
                i_in_valid <= 1'b0;
            end else if (byte_requests.size() != 0) begin
                next_req = byte_requests.pop_front();
                i_in_valid      <= 1'b1;
                i_byte_value    <= next_req.value;
                i_end_of_stream <= next_req.eos;
                send_gap = pick_gap(send_calm);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Corner-side receiver. After a dozen corners it holds ready low for a
    // long stretch once, so that the event queue inside the block fills and
    // the byte side stalls. Otherwise it pauses at random after a corner.
    // ------------------------------------------------------------------
    int   take_gap = 0;
    int   take_calm = 0;
    int   hold_left = 0;
    int   corners_taken = 0;
    logic held_once = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) corners_taken++;
            if (hold_left != 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (!held_once && corners_taken >= 12) begin
                held_once = 1'b1;
                hold_left = HOLD_CYCLES;
                i_out_ready <= 1'b0;
            end else if (take_gap != 0) begin
                take_gap--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
                if (o_out_valid && i_out_ready) take_gap = pick_gap(take_calm);
            end
        end
    end

    // ------------------------------------------------------------------
    // Scoreboard and watchdog. Delivered corners are checked before the
    // request accepted at the same edge is predicted, so a corner can never
    // be matched against an expectation that was only just created.
    // ------------------------------------------------------------------
    t_corner want;
    int      idle_cycles = 0;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (expected_corners.size() == 0) begin
                    $display("%0t: corner with nothing expected: x=%0d y=%0d last=%0b",
                             $time, o_corner_x, o_corner_y, o_last_corner);
                    mismatches++;
                end else begin
                    want = expected_corners.pop_front();
                    if (o_corner_x !== want.x) begin
                        $display("%0t: corner_x expected %0d, got %0d",
                                 $time, want.x, o_corner_x);
                        mismatches++;
                    end
                    if (o_corner_y !== want.y) begin
                        $display("%0t: corner_y expected %0d, got %0d",
                                 $time, want.y, o_corner_y);
                        mismatches++;
                    end
                    if (o_last_corner !== want.last) begin
                        $display("%0t: last_corner expected %0b, got %0b",
                                 $time, want.last, o_last_corner);
                        mismatches++;
                    end
                end
            end
            if (i_in_valid && o_in_ready) predict_request(i_byte_value, i_end_of_stream);

            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no request moved for %0d cycles", $time, IDLE_LIMIT);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------
    int streams = 0;

    initial begin
        clear_all();

        // End of stream straight after reset: the header never ended, no
        // word was seen, and the empty starting rectangle comes out.
        push_eos();
        // A header that is only a blank line, written with carriage returns.
        push_byte(CHAR_CR);
        push_byte(CHAR_LF);
        push_byte(CHAR_CR);
        push_byte(CHAR_LF);
        // Lower-case letter, negative value, number ended by a zero byte.
        push_text("x-7");
        push_byte(8'h00);
        push_byte(CHAR_SPACE);
        // A magnitude past the cap once scaled.
        push_text("y200000 ");
        // A word whose letter is a zero byte is ignored.
        push_byte(8'h00);
        push_byte(CHAR_SPACE);
        // Padding, then a point with no digits: the value is zero.
        push_byte(CHAR_X);
        push_byte(CHAR_TAB);
        push_byte(CHAR_POINT);
        push_byte(CHAR_SPACE);
        // A word left open at end of stream is dropped.
        push_text("Y1");
        push_eos();

        while (byte_requests.size() < 260 || streams < 8) begin
            push_stream();
            streams++;
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(posedge i_clk);
        while (byte_requests.size() != 0 || i_in_valid || expected_corners.size() != 0);
        // Let any stray corner surface before the verdict.
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
